[sv/mbnu_pkg.sv]
// Shared types and constants for the mark bitmap / next-unmarked search block.
// No dependencies; imported by the scan unit, the register file and the top level.
`timescale 1ns / 1ps

package mbnu_pkg;

    // field widths
    localparam int IDX_W   = 17;   // entry index, count, found index
    localparam int POS_W   = 18;   // word base while walking (may pass the count)
    localparam int BIT_W   = 6;    // bit position inside a word (word <= 64 bits)
    localparam int TDATA_W = 24;   // 17-bit field padded to whole bytes

    // default sizing
    localparam int DEF_MAX_ENTRIES = 65536;
    localparam int DEF_WORD_BITS   = 64;

    // operation codes (tuser bit of the input request)
    localparam logic OP_MARK = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // configuration port
    localparam int   PADDR_W          = 3;
    localparam int   PDATA_W          = 32;
    localparam logic REG_SYMBOL_COUNT = 1'b0;   // register index (paddr[2])

    // result of the in-word lowest-bit search
    typedef struct packed {
        logic             done;
        logic [BIT_W-1:0] bit_pos;
    } scan_res_t;

endpackage

[sv/mark_bitmap_next_unmarked_top.sv]
// Mark bitmap with next-unmarked-entry search: top level.
// Depends on mbnu_pkg, mbnu_ram, mbnu_bit_scan and mbnu_apb_regs.
`timescale 1ns / 1ps

// One mark bit per entry, packed into WORD_BITS-wide words held in a single
// synchronous RAM. A mark request (tuser = 0) sets the bit of tdata's index; a
// find request (tuser = 1) returns the lowest unmarked index at or above the
// start, or the active count (min(symbol_count, MAX_ENTRIES)) when none is left.
// Out-of-range requests return index 0 with range_error set and change nothing.
// After reset the RAM is cleared one word per cycle; no request is taken until
// that pass is over, though register writes are. One request is in flight at a
// time. An out-of-range request (mark or find) or a find at the count goes
// straight to the result; any other request reads its word, and a mark writes
// it back while a find walks on until a word has an unmarked bit or the count
// is passed, then searches that word in the bit search unit. The per-word loop
// is one RAM read per cycle. The result sits in an output register, so a new
// request is taken while the previous result still waits for m_tready; the new
// result is held until that output register is free.
module mark_bitmap_next_unmarked_top
    import mbnu_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int WORD_BITS   = DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [16:0] entry_index
    input  logic [0:0]         s_tuser,   // [0] operation
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [16:0] found_index
    output logic [0:0]         m_tuser,   // [0] range_error
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int WORD_COUNT = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // word index = idx / WORD_BITS via reciprocal, exact for any 17-bit idx
    localparam int    DIV_SHIFT = IDX_W + $clog2(WORD_BITS);
    localparam int    RECIP_W   = IDX_W + 1;
    localparam int    PROD_W    = IDX_W + RECIP_W;
    localparam longint DIV_RECIP = ((64'd1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    // state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_OFF   = 3'd3;
    localparam logic [2:0] S_WORD  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg;

    // request context
    logic             op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] q_reg;
    logic [AW-1:0]    w_reg;
    logic [POS_W-1:0] base_reg;
    logic [BIT_W-1:0] off_reg;

    // pending result and output register
    logic [IDX_W-1:0] res_found_reg;
    logic             res_err_reg;
    logic             m_tvalid_reg;
    logic [IDX_W-1:0] m_found_reg;
    logic             m_err_reg;

    // config
    logic [IDX_W-1:0] symbol_count;
    logic [IDX_W-1:0] cnt_now;

    // request decode
    logic             in_op;
    logic [IDX_W-1:0] in_idx;
    logic             in_accept;
    logic             in_err;
    logic             in_at_count;

    // datapath
    logic [PROD_W-1:0]    prod;
    logic [POS_W-1:0]     base_calc;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] masked;
    logic [POS_W-1:0]     next_base;
    logic                 past_count;
    logic [POS_W-1:0]     hit_pos;
    logic                 out_free;

    // RAM ports
    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [WORD_BITS-1:0] wr_data;

    // bit search
    logic                 scan_start;
    scan_res_t            scan_res;

    mbnu_apb_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .symbol_count (symbol_count)
    );

    mbnu_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_marks (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mbnu_bit_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .word    (masked),
        .res     (scan_res)
    );

    // active count clamps to the bitmap size
    always_comb begin
        if (32'(symbol_count) > 32'(MAX_ENTRIES)) begin
            cnt_now = IDX_W'(MAX_ENTRIES);
        end else begin
            cnt_now = symbol_count;
        end
    end

    assign in_op       = s_tuser[0];
    assign in_idx      = s_tdata[IDX_W-1:0];
    assign s_tready    = (state_reg == S_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign in_err      = (in_op == OP_MARK) ? (in_idx >= cnt_now) : (in_idx > cnt_now);
    assign in_at_count = (in_op == OP_FIND) && (in_idx == cnt_now);

    assign prod      = PROD_W'(idx_reg) * PROD_W'(DIV_RECIP);
    assign base_calc = POS_W'(q_reg) * POS_W'(WORD_BITS);

    // unmarked bits at or above the offset in the word just read
    assign masked     = ~rd_data & (ALL_ONES << off_reg);
    assign next_base  = base_reg + POS_W'(WORD_BITS);
    assign past_count = (next_base >= POS_W'(cnt_reg));
    assign hit_pos    = base_reg + POS_W'(scan_res.bit_pos);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign scan_start = (state_reg == S_WORD) && (op_reg == OP_FIND) && (masked != '0);

    // RAM access: clear sweep, first read, walk reads, mark write-back
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = w_reg + AW'(1);
        wr_en   = 1'b0;
        wr_addr = w_reg;
        wr_data = rd_data | (WORD_BITS'(1) << off_reg);
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            S_OFF: begin
                rd_en   = 1'b1;
                rd_addr = AW'(q_reg);
            end
            S_WORD: begin
                if (op_reg == OP_MARK) begin
                    wr_en = 1'b1;
                end else if (masked == '0 && !past_count) begin
                    rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == AW'(WORD_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    state_next = (in_err || in_at_count) ? S_EMIT : S_DIV;
                end
            end
            S_DIV:  state_next = S_OFF;
            S_OFF:  state_next = S_WORD;
            S_WORD: begin
                if (op_reg == OP_MARK) begin
                    state_next = S_EMIT;
                end else if (masked != '0) begin
                    state_next = S_SCAN;
                end else if (past_count) begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    op_reg        <= in_op;
                    idx_reg       <= in_idx;
                    cnt_reg       <= cnt_now;
                    res_err_reg   <= in_err;
                    res_found_reg <= (in_at_count && !in_err) ? cnt_now : '0;
                end
            end
            S_DIV: begin
                q_reg <= IDX_W'(prod >> DIV_SHIFT);
            end
            S_OFF: begin
                w_reg    <= AW'(q_reg);
                base_reg <= base_calc;
                off_reg  <= BIT_W'(POS_W'(idx_reg) - base_calc);
            end
            S_WORD: begin
                if (op_reg == OP_MARK) begin
                    res_found_reg <= '0;
                end else if (masked == '0) begin
                    if (past_count) begin
                        res_found_reg <= cnt_reg;
                    end
                    w_reg    <= w_reg + AW'(1);
                    base_reg <= next_base;
                    off_reg  <= '0;
                end
            end
            S_SCAN: begin
                // a hit at or beyond the count means nothing left below it
                if (scan_res.done) begin
                    res_found_reg <= (hit_pos >= POS_W'(cnt_reg)) ? cnt_reg
                                                                 : IDX_W'(hit_pos);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_found_reg <= res_found_reg;
                    m_err_reg   <= res_err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = TDATA_W'(m_found_reg);
    assign m_tuser[0] = m_err_reg;

    // no request taken during the clear sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken while clearing");

    // an error result carries index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result with nonzero index");

    // found index never passes the active count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[IDX_W-1:0] <= cnt_reg))
        else $error("found index beyond count");

    // the bitmap is written only by the clear sweep or a mark write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((state_reg == S_CLEAR) || (state_reg == S_WORD && op_reg == OP_MARK)))
        else $error("unexpected bitmap write");

    // reads stay inside the bitmap
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (32'(rd_addr) < 32'(WORD_COUNT)))
        else $error("bitmap read out of range");

    // a started bit search is always followed by the search state
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start |=> (state_reg == S_SCAN))
        else $error("bit search started outside the walk");

endmodule

[sv/mbnu_ram.sv]
// Generic single-clock RAM, one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbnu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/mbnu_bit_scan.sv]
// Lowest-set-bit search over one mark word: byte group first, then bit in byte.
// Depends on mbnu_pkg. The result is registered and flagged by done.
`timescale 1ns / 1ps

module mbnu_bit_scan
    import mbnu_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] word,
    output scan_res_t            res
);

    localparam int NGROUP = (WORD_BITS + 7) / 8;
    localparam int PAD_W  = NGROUP * 8;
    localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [GW-1:0]        grp_reg;
    logic [7:0]           byte_reg;
    logic [BIT_W-1:0]     pos_reg;

    logic [PAD_W-1:0]     padded;
    logic [GW-1:0]        grp_next;
    logic [7:0]           byte_next;
    logic [2:0]           bit_sel;
    logic [BIT_W-1:0]     pos_next;

    // stage 1: lowest nonzero byte group
    always_comb begin
        padded   = PAD_W'(word_reg);
        grp_next = '0;
        for (int g = NGROUP - 1; g >= 0; g--) begin
            if (|padded[g*8 +: 8]) begin
                grp_next = GW'(g);
            end
        end
        byte_next = padded[8*grp_next +: 8];
    end

    // stage 2: lowest set bit in that byte
    always_comb begin
        bit_sel = '0;
        for (int b = 7; b >= 0; b--) begin
            if (byte_reg[b]) begin
                bit_sel = 3'(b);
            end
        end
        pos_next = BIT_W'({grp_reg, bit_sel});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            word_reg <= word;
        end
        grp_reg  <= grp_next;
        byte_reg <= byte_next;
        pos_reg  <= pos_next;
    end

    assign res.done    = v3_reg;
    assign res.bit_pos = pos_reg;

endmodule

[sv/mbnu_apb_regs.sv]
// Configuration register file behind an APB-style port (symbol_count only).
// Depends on mbnu_pkg.
`timescale 1ns / 1ps

module mbnu_apb_regs
    import mbnu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [IDX_W-1:0]   symbol_count
);

    logic             reg_index;
    logic             wr_strobe;
    logic [IDX_W-1:0] symbol_count_reg;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= '0;
        end else if (wr_strobe && reg_index == REG_SYMBOL_COUNT) begin
            symbol_count_reg <= pwdata[IDX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_SYMBOL_COUNT) begin
            prdata = PDATA_W'(symbol_count_reg);
        end
    end

    assign symbol_count = symbol_count_reg;

endmodule
